[hdl/abd_pkg.sv]
// Types and constants shared by the adaptive beat detector.
// No dependencies.
`timescale 1ns / 1ps
package abd_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned LEVEL_W  = 25;
    localparam int unsigned THR_W    = 24;
    localparam int unsigned STR_W    = 16;
    localparam int unsigned RATE_W   = 17;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned DIV_W    = 34;

    localparam logic [STR_W-1:0]  STRENGTH_MAX = 16'hFFFF;
    localparam logic [THR_W-1:0]  THR_RESET    = 24'd25600;
    localparam logic [CNT_W-1:0]  HALVE_AT     = 7'd100;
    localparam logic [RATE_W-1:0] RATE_ONE     = 17'd65536;
    localparam logic [7:0]        LPF_RESET    = 8'd1;
    localparam logic [RATE_W-1:0] TARGET_RESET = 17'd6554;

    localparam logic REG_LPF    = 1'b0;
    localparam logic REG_TARGET = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_frame;
    } in_word_t;

    typedef struct packed {
        logic [STR_W-1:0]  beat_strength;
        logic              beat_found;
        logic [RATE_W-1:0] beat_rate;
        logic [THR_W-1:0]  new_threshold;
    } out_word_t;

    typedef struct packed {
        logic load;        // capture sample, form numerator
        logic div_start;   // start divider (level, step or rate)
        logic rate_done;   // latch rate quotient
        logic level_done;  // latch level, form step
        logic strength_add;
        logic frame_count; // update counts
        logic rate_div;
        logic finish;      // form threshold, output word
    } abd_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic need_step_div;
        logic last;
    } abd_sts_t;

endpackage

[hdl/abd_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Uses abd_pkg.
`timescale 1ns / 1ps
module abd_divider
    import abd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [THR_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);
    localparam int unsigned CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg, q_next;
    logic [THR_W:0]   rem_reg, rem_next;
    logic [THR_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [THR_W+1:0] trial;

    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg, q_reg[DIV_W-1]} - {2'b00, dvs_reg};
        if (cnt_reg != '0)
        begin
            if (!trial[THR_W+1])
            begin
                rem_next = trial[THR_W:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[THR_W-1:0], q_reg[DIV_W-1]};
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CW'(DIV_W);
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;
endmodule

[hdl/abd_datapath.sv]
// Datapath: level filter, strength sum, frame counts, threshold adaptation.
// Uses abd_pkg and abd_divider.
`timescale 1ns / 1ps
module abd_datapath
    import abd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  abd_cmd_t          cmd,
    output abd_sts_t          sts,
    input  in_word_t          in_word,
    input  logic [7:0]        lpf,
    input  logic [RATE_W-1:0] target,
    output out_word_t         result
);
    logic signed [LEVEL_W-1:0] level_reg;
    logic [STR_W-1:0]          str_reg;
    logic [THR_W-1:0]          thr_reg;
    logic [CNT_W-1:0]          fc_reg, dc_reg;
    logic                      last_reg;
    logic                      neg_reg;
    logic [DIV_W-1:0]          mag_reg;
    logic [THR_W-1:0]          dvs_reg;
    logic [LEVEL_W:0]          step_reg;
    logic [RATE_W-1:0]         rate_reg;
    out_word_t                 result_reg;

    logic [8:0]                div_l;
    logic signed [DIV_W-1:0]   num;
    logic                      div_busy;
    logic [DIV_W-1:0]          quot;
    logic signed [LEVEL_W-1:0] new_level;
    logic signed [LEVEL_W:0]   diff;
    logic [STR_W:0]            sum;
    logic [CNT_W-1:0]          fc_inc, dc_inc;
    logic [RATE_W-1:0]         tgt;
    logic signed [36:0]        thr16;
    logic [THR_W-1:0]          thr_new;
    logic [DIV_W-1:0]          step_ext;

    // (div-1)*prev fits in 33 bits plus sign
    always_comb
    begin
        div_l = (lpf == 8'd0) ? 9'd1 : {1'b0, lpf};
        num   = DIV_W'($signed({in_word.sample, 8'b0}))
              + DIV_W'($signed({1'b0, div_l - 9'd1})) * DIV_W'(level_reg);
    end

    abd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mag_reg),
        .divisor  (dvs_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign new_level = neg_reg ? -LEVEL_W'(quot) : LEVEL_W'(quot);
    assign diff      = {new_level[LEVEL_W-1], new_level} - {level_reg[LEVEL_W-1], level_reg};
    assign step_ext  = DIV_W'(step_reg);
    assign sum       = {1'b0, str_reg} + {1'b0, (quot > DIV_W'(STRENGTH_MAX))
                                                ? STRENGTH_MAX : quot[STR_W-1:0]};

    always_comb
    begin
        fc_inc = fc_reg + 1'b1;
        dc_inc = (str_reg != '0) ? dc_reg + 1'b1 : dc_reg;
        tgt    = (target > RATE_ONE) ? RATE_ONE : target;
        thr16  = $signed({5'b0, thr_reg, 8'b0})
               - 37'sd10 * ($signed({20'b0, tgt}) - $signed({20'b0, rate_reg}));
        // clamp at zero, saturate above the threshold range
        if (thr16 < 0)
            thr_new = '0;
        else if (thr16[36:THR_W+8] != '0)
            thr_new = {THR_W{1'b1}};
        else
            thr_new = thr16[THR_W+7:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            str_reg   <= '0;
            thr_reg   <= THR_RESET;
            fc_reg    <= '0;
            dc_reg    <= '0;
        end
        else
        begin
            if (cmd.level_done)
                level_reg <= new_level;
            if (cmd.strength_add)
                str_reg <= sum[STR_W] ? STRENGTH_MAX : sum[STR_W-1:0];
            if (cmd.frame_count)
            begin
                if (fc_inc >= HALVE_AT)
                begin
                    fc_reg <= fc_inc >> 1;
                    dc_reg <= dc_inc >> 1;
                end
                else
                begin
                    fc_reg <= fc_inc;
                    dc_reg <= dc_inc;
                end
            end
            if (cmd.finish)
            begin
                str_reg <= '0;
                thr_reg <= thr_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            last_reg <= in_word.last_in_frame;
            neg_reg  <= num[DIV_W-1];
            mag_reg  <= num[DIV_W-1] ? -num : num;
            dvs_reg  <= THR_W'(div_l);
        end
        if (cmd.level_done)
        begin
            step_reg <= diff[LEVEL_W] ? -diff : diff;
            neg_reg  <= 1'b0;
            // zero threshold: quotient saturates, divider gives all ones
            mag_reg  <= DIV_W'(diff[LEVEL_W] ? -diff : diff);
            dvs_reg  <= thr_reg;
        end
        if (cmd.rate_div)
        begin
            mag_reg <= DIV_W'({fc_reg != '0 ? dc_reg : 7'd0, 16'b0});
            dvs_reg <= (fc_reg == '0) ? THR_W'(1) : THR_W'(fc_reg);
        end
        if (cmd.rate_done)
            rate_reg <= (quot > DIV_W'(RATE_ONE)) ? RATE_ONE : quot[RATE_W-1:0];
        if (cmd.finish)
        begin
            result_reg.beat_strength <= str_reg;
            result_reg.beat_found    <= (str_reg != '0);
            result_reg.beat_rate     <= rate_reg;
            result_reg.new_threshold <= thr_new;
        end
    end

    assign sts.div_busy      = div_busy;
    assign sts.need_step_div = (step_ext != '0) && (step_ext > DIV_W'(thr_reg));
    assign sts.last          = last_reg;
    assign result            = result_reg;
endmodule

[hdl/abd_ctrl.sv]
// Controller sequencing one sample through the shared divider.
// Uses abd_pkg.
`timescale 1ns / 1ps
module abd_ctrl
    import abd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  abd_sts_t sts,
    output abd_cmd_t cmd
);
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LVL    = 10'b0000000010,
        S_LWAIT  = 10'b0000000100,
        S_STEP   = 10'b0000001000,
        S_SWAIT  = 10'b0000010000,
        S_CNT    = 10'b0000100000,
        S_RATE   = 10'b0001000000,
        S_RGO    = 10'b0010000000,
        S_RWAIT  = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ov_next    = ov_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LVL;
                end
            S_LVL:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_LWAIT;
            end
            S_LWAIT:
                if (!sts.div_busy)
                begin
                    cmd.level_done = 1'b1;
                    state_next     = S_STEP;
                end
            S_STEP:
                if (sts.need_step_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_SWAIT;
                end
                else
                    state_next = sts.last ? S_CNT : S_IDLE;
            S_SWAIT:
                if (!sts.div_busy)
                begin
                    cmd.strength_add = 1'b1;
                    state_next       = sts.last ? S_CNT : S_IDLE;
                end
            S_CNT:
            begin
                cmd.frame_count = 1'b1;
                state_next      = S_RATE;
            end
            S_RATE:
            begin
                cmd.rate_div = 1'b1;
                state_next   = S_RGO;
            end
            // rate operands are loaded, start the division
            S_RGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_RWAIT;
            end
            S_RWAIT:
                if (!sts.div_busy)
                begin
                    cmd.rate_done = 1'b1;
                    state_next    = S_FIN;
                end
            S_FIN:
                // hold until the output register is free or being taken
                if (!ov_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
endmodule

[hdl/adaptive_beat_detector_core.sv]
// Top level of the adaptive beat detector.
// Uses abd_pkg, abd_ctrl, abd_datapath.
//
// Channels: input words (sample, last_in_frame) on in_valid/in_ready;
// one result word per frame on out_valid/out_ready; register writes on
// cfg_valid/cfg_ready (index 0 lowpass_factor, 1 beat_rate_target),
// always ready; write registers only while no word is in flight.
// One sample at a time: each accepted sample is loaded, runs a filter
// division in the shared restoring divider, has its level latched and its
// step checked; a second division forms the strength increment when the
// level step exceeds the threshold.
// A frame's last sample adds the count update and a rate division; its
// result word becomes valid in the same cycle that in_ready returns.
// Results sit in an output register; the next samples are accepted while
// a result waits, and only the next frame end holds until the word is taken.
// Reset clears level, strength, counts, threshold to 100.0 and registers
// to their defaults.
`timescale 1ns / 1ps
module adaptive_beat_detector_core
    import abd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_word_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [RATE_W-1:0] cfg_data
);
    logic [7:0]        lpf_reg;
    logic [RATE_W-1:0] tgt_reg;
    abd_cmd_t          cmd;
    abd_sts_t          sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpf_reg <= LPF_RESET;
            tgt_reg <= TARGET_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LPF:    lpf_reg <= cfg_data[7:0];
                REG_TARGET: tgt_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    abd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    abd_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .in_word (in_data),
        .lpf     (lpf_reg),
        .target  (tgt_reg),
        .result  (out_data)
    );
endmodule

[hdl/abd_checker.sv]
// Port-level checks for the adaptive beat detector.
// Uses abd_pkg; bound to adaptive_beat_detector_core.
`timescale 1ns / 1ps
module abd_checker
    import abd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.beat_found == (out_data.beat_strength != '0)))
        else $error("beat_found disagrees with strength");
    a_rate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.beat_rate <= RATE_ONE))
        else $error("beat rate above one");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word dropped");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted two words back to back");
endmodule

bind adaptive_beat_detector_core abd_checker u_abd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[bench/tb_top.sv]
// Self-checking bench for adaptive_beat_detector_core: directed table, then random frames.
// Depends on abd_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
    import abd_pkg::*;

    localparam int unsigned STALL_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] smp;
        logic               last;
        logic               chk;
        out_word_t          want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_word_t          in_data;
    logic              out_valid;
    logic              out_ready;
    out_word_t         out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [RATE_W-1:0] cfg_data;

    // predictor state
    logic [7:0]         lpf_div;
    logic [RATE_W-1:0]  rate_target;
    logic signed [31:0] level_q8;
    logic [31:0]        strength_acc;
    logic [31:0]        thr_q8;
    logic [6:0]         frames_seen;
    logic [6:0]         frames_hit;

    out_word_t   frame_results[$];
    logic        result_known[$];
    int          err_count;
    int          words_in;
    int          words_out;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_off;
    logic        timed_out;
    stim_row_t   rows[$];

    adaptive_beat_detector_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at result %0d: %s got %0d want %0d", words_out, what, got, want);
        err_count++;
    endtask

    function automatic void predictor_reset();
        lpf_div      = LPF_RESET;
        rate_target  = TARGET_RESET;
        level_q8     = 0;
        strength_acc = 0;
        thr_q8       = THR_RESET;
        frames_seen  = 0;
        frames_hit   = 0;
    endfunction

    // Advance predictor by one sample; returns 1 when a frame result is produced.
    function automatic bit predict_sample(input in_word_t w, output out_word_t res);
        longint dv, prev, num, stp, tq, tgt, rt;
        dv   = (lpf_div == 0) ? 1 : lpf_div;
        prev = level_q8;
        num  = longint'(w.sample) * 256 + (dv - 1) * prev;
        level_q8 = 32'(num / dv);
        stp  = longint'(level_q8) - prev;
        if (stp < 0)
            stp = -stp;
        if (thr_q8 == 0)
        begin
            if (stp > 0)
                strength_acc = STRENGTH_MAX;
        end
        else if (stp > thr_q8)
        begin
            strength_acc = strength_acc + stp / thr_q8;
            if (strength_acc > STRENGTH_MAX)
                strength_acc = STRENGTH_MAX;
        end
        res = '0;
        if (!w.last_in_frame)
            return 0;
        frames_seen = frames_seen + 1;
        if (strength_acc != 0)
            frames_hit = frames_hit + 1;
        if (frames_seen >= HALVE_AT)
        begin
            frames_seen = frames_seen >> 1;
            frames_hit  = frames_hit >> 1;
        end
        rt = (frames_seen == 0) ? 0 : (longint'(frames_hit) << 16) / frames_seen;
        if (rt > RATE_ONE)
            rt = RATE_ONE;
        tgt = (rate_target > RATE_ONE) ? RATE_ONE : rate_target;
        tq = longint'(thr_q8) * 256 - 10 * (tgt - rt);
        if (tq < 0)
            tq = 0;
        tq = tq >>> 8;
        if (tq > 24'hFFFFFF)
            tq = 24'hFFFFFF;
        thr_q8 = 32'(tq);
        res.beat_strength = strength_acc[15:0];
        res.beat_found    = (strength_acc != 0);
        res.beat_rate     = rt[16:0];
        res.new_threshold = tq[23:0];
        strength_acc = 0;
        return 1;
    endfunction

    // Leaves in_valid high after the accepting edge; the caller drops it
    // at the end of a burst.
    task automatic send_sample(input logic signed [15:0] s, input logic l,
                               input logic chk, input out_word_t want);
        in_word_t  w;
        out_word_t res;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        w.sample        = s;
        w.last_in_frame = l;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (predict_sample(w, res))
        begin
            if (chk)
                frame_results.push_back(want);
            else
                frame_results.push_back(res);
            result_known.push_back(chk);
        end
        words_in++;
    endtask

    task automatic write_reg(input logic idx, input logic [RATE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_LPF)
            lpf_div = val[7:0];
        else
            rate_target = val;
        @(posedge clk);
    endtask

    task automatic drain();
        while (frame_results.size() != 0)
            @(posedge clk);
        // a non-final sample may still be in the divider
        repeat (150) @(posedge clk);
    endtask

    // check results
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_results.size() == 0)
            begin
                report_mismatch("unexpected result word", out_data.beat_strength, 0);
            end
            else
            begin
                automatic out_word_t e = frame_results.pop_front();
                void'(result_known.pop_front());
                if (out_data.beat_strength !== e.beat_strength)
                    report_mismatch("beat_strength", out_data.beat_strength, e.beat_strength);
                if (out_data.beat_found !== e.beat_found)
                    report_mismatch("beat_found", out_data.beat_found, e.beat_found);
                if (out_data.beat_rate !== e.beat_rate)
                    report_mismatch("beat_rate", out_data.beat_rate, e.beat_rate);
                if (out_data.new_threshold !== e.new_threshold)
                    report_mismatch("new_threshold", out_data.new_threshold, e.new_threshold);
            end
            words_out++;
        end
    end

    // receiver: random stalls, plus a long hold when asked
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("watchdog expired");
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic out_word_t known(input int str, input int rt, input int thr);
        out_word_t o;
        o.beat_strength = str[15:0];
        o.beat_found    = (str != 0);
        o.beat_rate     = rt[16:0];
        o.new_threshold = thr[23:0];
        return o;
    endfunction

    task automatic add_row(input int s, input bit l, input bit chk, input out_word_t want);
        stim_row_t r;
        r.smp  = s[15:0];
        r.last = l;
        r.chk  = chk;
        r.want = want;
        rows.push_back(r);
    endtask

    task automatic random_frames(input int n_items);
        int left;
        int flen;
        int mode;
        logic signed [15:0] s;
        left = n_items;
        while (left > 0)
        begin
            flen = $urandom_range(1, 12);
            mode = $urandom_range(3);
            for (int k = 0; k < flen && left > 0; k++)
            begin
                case (mode)
                    0: s = 16'($urandom);
                    1: s = ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
                    2: s = 16'($signed($urandom_range(0, 600)) - 300);
                    default: s = ($urandom_range(3) == 0) ? 16'($urandom) : 16'sd0;
                endcase
                send_sample(s, (k == flen - 1), 1'b0, '0);
                left--;
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_LPF;
        cfg_data      = '0;
        out_ready     = 1'b0;
        hold_off      = 1'b0;
        timed_out     = 1'b0;
        err_count     = 0;
        words_in      = 0;
        words_out     = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        predictor_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset, L=1: level follows the sample; first frame one sample.
        // zero sample: no step, rate 0, thr = 25600 - (10*6554)/256 rounded down
        add_row(0, 1, 1, known(0, 0, 25343));
        add_row(32767, 0, 0, '0);
        add_row(-32768, 0, 0, '0);
        add_row(0, 1, 0, '0);
        add_row(1, 1, 0, '0);
        add_row(-1, 0, 0, '0);
        add_row(32767, 1, 0, '0);
        for (int i = 0; i < rows.size(); i++)
            send_sample(rows[i].smp, rows[i].last, rows[i].chk, rows[i].want);
        in_valid <= 1'b0;
        drain();

        // Max target lowers the threshold; then LPF 0, target above one, full-scale steps.
        write_reg(REG_TARGET, RATE_ONE);
        write_reg(REG_LPF, 8'd255);
        for (int i = 0; i < 6; i++)
            send_sample(16'sh7FFF, 1'b0, 1'b0, '0);
        send_sample(-16'sd5, 1'b1, 1'b0, '0);
        in_valid <= 1'b0;
        drain();
        write_reg(REG_LPF, 8'd0);
        write_reg(REG_TARGET, 17'h1FFFF);
        send_sample(16'sh8000, 1'b1, 1'b0, '0);
        send_sample(16'sh7FFF, 1'b1, 1'b0, '0);
        in_valid <= 1'b0;
        drain();

        // Phase 1: sender idles lightly, receiver heavily.
        send_idle_pct = 28;
        recv_idle_pct = 74;
        write_reg(REG_TARGET, 17'd0);
        write_reg(REG_LPF, 8'd1);
        random_frames(300);
        drain();

        // Long receiver hold while the sender keeps pushing frames.
        send_idle_pct = 0;
        hold_off <= 1'b1;
        fork
            begin
                repeat (2000) @(posedge clk);
                hold_off <= 1'b0;
            end
            random_frames(60);
        join
        drain();

        // Phase 2: roles swapped.
        send_idle_pct = 74;
        recv_idle_pct = 28;
        write_reg(REG_LPF, 8'd4);
        write_reg(REG_TARGET, 17'd32768);
        random_frames(350);
        drain();

        // Phase 3: no idling, maximum LPF with the default target, then random settings.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_LPF, 8'd255);
        write_reg(REG_TARGET, 17'd6554);
        random_frames(200);
        drain();
        write_reg(REG_LPF, 8'($urandom_range(1, 255)));
        write_reg(REG_TARGET, 17'($urandom_range(0, 65536)));
        random_frames(200);
        drain();

        $display("Drove %0d samples and checked %0d frame results over several register settings.",
                 words_in, words_out);
        $display("Idling mixes, a long output hold and extreme register values were covered.");
        if (err_count == 0 && frame_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
